// ===== hw/rtl/selt_pkg.sv =====
`default_nettype none
package selt_pkg;

	localparam logic [2:0] CMD_GET_EXCL   = 3'd0;
	localparam logic [2:0] CMD_GET_SHARED = 3'd1;
	localparam logic [2:0] CMD_RELEASE    = 3'd2;
	localparam logic [2:0] CMD_QUERY_EXCL = 3'd3;
	localparam logic [2:0] CMD_QUERY_SHR  = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// Scan token handed from one cell to the next.
	typedef struct packed {
		logic       tok;
		logic       found;
		logic       free_seen;
		logic [1:0] status;
	} link_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_FINISH
	} fsm_t;

endpackage
`default_nettype wire

// ===== hw/rtl/shared_exclusive_lock_table.sv =====
`default_nettype none
// Shared/exclusive lock table. Each request word carries a command, a file id
// and a client (user, address, connection); one status word comes back per
// request. The entries live in a row of LOCK_ENTRIES cells, and a request is
// served by a scan token that moves one cell per clock along that row. The
// first cell that holds the file decides and applies the request on the spot;
// the first free cell marks itself so that a grant on an unowned file can
// claim it in the cycle the token leaves the row. The status word follows
// once the token has crossed the whole cell chain, and the block takes one
// request at a time: no new request is accepted until the status word of
// the last one is loaded. Requests with a zero user or an unknown command
// are refused without a scan.
// A finished status word waits in its own output register, and a new
// request is accepted while it waits.
module shared_exclusive_lock_table #(
	parameter int LOCK_ENTRIES      = 64,
	parameter int SHARERS_PER_ENTRY = 8,
	parameter int CONN_ID_BITS      = 8
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [2:0]              command,
	input  wire logic [31:0]             file_id,
	input  wire logic [31:0]             user_id,
	input  wire logic [31:0]             client_addr,
	input  wire logic [CONN_ID_BITS-1:0] conn_id,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [1:0]                   status
);

	// Request registers, broadcast to every cell during the scan.
	logic [2:0]              cmd_q;
	logic [31:0]             file_q;
	logic [31:0]             user_q;
	logic [31:0]             addr_q;
	logic [CONN_ID_BITS-1:0] conn_q;
	logic                    start_q;
	logic [1:0]              res_q;
	logic                    out_valid_q;
	logic [1:0]              status_q;

	selt_pkg::fsm_t  state_q;
	selt_pkg::fsm_t  state_d;
	selt_pkg::link_t link [LOCK_ENTRIES+1];

	logic accept;
	logic bad_req;
	logic scan_end;
	logic grant_cmd;
	logic claim;
	logic load_out;
	logic [1:0] scan_status;

	assign accept    = in_valid && in_ready;
	assign bad_req   = (user_id == 32'd0) || (command > selt_pkg::CMD_QUERY_SHR);
	assign scan_end  = (state_q == selt_pkg::FSM_SCAN) && link[LOCK_ENTRIES].tok;
	assign grant_cmd = (cmd_q == selt_pkg::CMD_GET_EXCL) ||
		(cmd_q == selt_pkg::CMD_GET_SHARED);
	// No entry holds the file: a grant claims the first free cell if there is one.
	assign claim     = scan_end && !link[LOCK_ENTRIES].found && grant_cmd &&
		link[LOCK_ENTRIES].free_seen;

	always_comb begin
		scan_status = link[LOCK_ENTRIES].status;
		if (!link[LOCK_ENTRIES].found) begin
			if (!grant_cmd) begin
				scan_status = selt_pkg::ST_REFUSED;
			end else if (link[LOCK_ENTRIES].free_seen) begin
				scan_status = selt_pkg::ST_OK;
			end else begin
				scan_status = selt_pkg::ST_FULL;
			end
		end
	end

	assign link[0] = '{tok: start_q, found: 1'b0, free_seen: 1'b0,
		status: selt_pkg::ST_REFUSED};

	for (genvar g = 0; g < LOCK_ENTRIES; g++) begin : g_cell
		selt_cell #(
			.SHARERS  (SHARERS_PER_ENTRY),
			.CONN_BITS(CONN_ID_BITS)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.link_i(link[g]),
			.link_o(link[g+1]),
			.cmd   (cmd_q),
			.file  (file_q),
			.user  (user_q),
			.addr  (addr_q),
			.conn  (conn_q),
			.claim (claim)
		);
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		case (state_q)
			selt_pkg::FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = bad_req ? selt_pkg::FSM_FINISH : selt_pkg::FSM_SCAN;
				end
			end
			selt_pkg::FSM_SCAN: begin
				if (scan_end) state_d = selt_pkg::FSM_FINISH;
			end
			selt_pkg::FSM_FINISH: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = selt_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = selt_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= selt_pkg::FSM_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= accept && !bad_req;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= command;
			file_q <= file_id;
			user_q <= user_id;
			addr_q <= client_addr;
			conn_q <= conn_id;
			res_q  <= selt_pkg::ST_REFUSED;
		end else if (scan_end) begin
			res_q <= scan_status;
		end
		if (load_out) status_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != 2'd3))
		else $error("status word carries an unused code");

	a_claim_scan: assert property (@(posedge clk) disable iff (!arst_n)
		claim |-> (state_q == selt_pkg::FSM_SCAN) && !link[LOCK_ENTRIES].found)
		else $error("entry claimed outside the end of a scan");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> $past(state_q == selt_pkg::FSM_IDLE))
		else $error("scan started without a new request");

	a_load_once: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (state_q == selt_pkg::FSM_IDLE) && out_valid)
		else $error("status word not presented after finishing");

endmodule
`default_nettype wire

// ===== hw/rtl/selt_cell.sv =====
`default_nettype none
// One lock entry. It reacts when the scan token passes through it.
module selt_cell #(
	parameter int SHARERS   = 8,
	parameter int CONN_BITS = 8
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire selt_pkg::link_t       link_i,
	output selt_pkg::link_t            link_o,
	input  wire logic [2:0]            cmd,
	input  wire logic [31:0]           file,
	input  wire logic [31:0]           user,
	input  wire logic [31:0]           addr,
	input  wire logic [CONN_BITS-1:0]  conn,
	input  wire logic                  claim
);

	logic                 valid_q;
	logic                 xv_q;
	logic                 cand_q;
	logic [SHARERS-1:0]   sv_q;
	logic [31:0]          file_q;
	logic [31:0]          ou_q;
	logic [31:0]          oa_q;
	logic [CONN_BITS-1:0] xc_q;
	logic [CONN_BITS-1:0] sc_q [SHARERS];

	logic                 hit;
	logic                 free_here;
	logic                 owner;
	logic                 excl_m;
	logic [SHARERS-1:0]   smv;
	logic [SHARERS-1:0]   sm_first;
	logic [SHARERS-1:0]   fv;
	logic [SHARERS-1:0]   free_first;
	logic                 smatch;
	logic [1:0]           st_hit;
	logic [SHARERS-1:0]   set_slot;
	logic [SHARERS-1:0]   clr_slot;
	logic                 free_all;
	logic                 do_claim;
	selt_pkg::link_t      link_d;

	always_comb begin
		for (int s = 0; s < SHARERS; s++) begin
			smv[s] = sv_q[s] && (sc_q[s] == conn);
		end
	end

	assign hit        = link_i.tok && !link_i.found && valid_q && (file_q == file);
	assign free_here  = link_i.tok && !link_i.found && !link_i.free_seen && !valid_q;
	assign owner      = (ou_q == user) && (oa_q == addr);
	assign excl_m     = xv_q && (xc_q == conn);
	assign smatch     = |smv;
	assign sm_first   = smv & (~smv + 1'b1);
	assign fv         = ~sv_q;
	assign free_first = fv & (~fv + 1'b1);
	assign do_claim   = claim && cand_q;

	always_comb begin
		st_hit   = selt_pkg::ST_REFUSED;
		set_slot = '0;
		clr_slot = '0;
		free_all = 1'b0;
		case (cmd)
			selt_pkg::CMD_GET_SHARED: begin
				if (owner && !smatch) begin
					if (|fv) begin
						set_slot = free_first;
						st_hit   = selt_pkg::ST_OK;
					end else begin
						st_hit = selt_pkg::ST_FULL;
					end
				end
			end
			selt_pkg::CMD_RELEASE: begin
				if (owner) begin
					if (excl_m) begin
						free_all = 1'b1;
						st_hit   = selt_pkg::ST_OK;
					end else if (smatch) begin
						clr_slot = sm_first;
						free_all = ((sv_q & ~sm_first) == '0);
						st_hit   = selt_pkg::ST_OK;
					end
				end
			end
			selt_pkg::CMD_QUERY_EXCL: begin
				if (owner && excl_m) st_hit = selt_pkg::ST_OK;
			end
			selt_pkg::CMD_QUERY_SHR: begin
				if (owner && smatch) st_hit = selt_pkg::ST_OK;
			end
			default: begin
				st_hit = selt_pkg::ST_REFUSED;
			end
		endcase
		if (!hit) begin
			set_slot = '0;
			clr_slot = '0;
			free_all = 1'b0;
		end
	end

	always_comb begin
		link_d.tok       = link_i.tok;
		link_d.found     = link_i.found | hit;
		link_d.free_seen = link_i.free_seen | free_here | (link_i.tok & !valid_q);
		link_d.status    = hit ? st_hit : link_i.status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			xv_q    <= 1'b0;
			sv_q    <= '0;
			cand_q  <= 1'b0;
			link_o  <= '0;
		end else begin
			link_o <= link_d;
			if (link_i.tok) begin
				cand_q <= free_here;
			end
			if (do_claim) begin
				valid_q <= 1'b1;
				xv_q    <= (cmd == selt_pkg::CMD_GET_EXCL);
				sv_q    <= (cmd == selt_pkg::CMD_GET_SHARED) ?
					SHARERS'(1) : '0;
			end else if (free_all) begin
				valid_q <= 1'b0;
				xv_q    <= 1'b0;
				sv_q    <= '0;
			end else begin
				sv_q <= (sv_q | set_slot) & ~clr_slot;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_claim) begin
			file_q   <= file;
			ou_q     <= user;
			oa_q     <= addr;
			xc_q     <= conn;
			sc_q[0]  <= conn;
		end
		for (int s = 0; s < SHARERS; s++) begin
			if (set_slot[s]) sc_q[s] <= conn;
		end
	end

endmodule
`default_nettype wire
